>>> sv/lts_pkg.sv
// Shared types, token kind codes and character tables for the token scanner.
package lts_pkg;

    localparam int KEYWORD_BYTES_DEF = 8;
    localparam int LEVEL_BITS_DEF    = 8;
    localparam int FIFO_DEPTH        = 4;

    localparam logic [30:0] LINE_TOP = 31'h7FFF_FFFF;
    localparam logic [31:0] OFF_TOP  = 32'hFFFF_FFFF;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_NUMBER  = 6'd2;
    localparam logic [5:0] K_STRING  = 6'd3;
    localparam logic [5:0] K_KW0     = 6'd4;
    localparam logic [5:0] K_MINUS   = 6'd34;
    localparam logic [5:0] K_DCOLON  = 6'd41;
    localparam logic [5:0] K_COLON   = 6'd42;
    localparam logic [5:0] K_IDIV    = 6'd43;
    localparam logic [5:0] K_DIV     = 6'd44;
    localparam logic [5:0] K_NE      = 6'd45;
    localparam logic [5:0] K_TILDE   = 6'd46;
    localparam logic [5:0] K_EQ      = 6'd47;
    localparam logic [5:0] K_ASSIGN  = 6'd48;
    localparam logic [5:0] K_LE      = 6'd49;
    localparam logic [5:0] K_SHL     = 6'd50;
    localparam logic [5:0] K_LT      = 6'd51;
    localparam logic [5:0] K_GE      = 6'd52;
    localparam logic [5:0] K_SHR     = 6'd53;
    localparam logic [5:0] K_GT      = 6'd54;
    localparam logic [5:0] K_DOTS3   = 6'd55;
    localparam logic [5:0] K_CONCAT  = 6'd56;
    localparam logic [5:0] K_DOT     = 6'd57;
    localparam logic [5:0] K_LBRACK  = 6'd58;
    localparam logic [5:0] K_ERROR   = 6'd59;

    localparam logic [63:0] KW_TEXT [22] = '{
        "and", "break", "do", "else", "elseif", "end", "false", "for",
        "function", "goto", "if", "in", "local", "nil", "not", "or",
        "repeat", "return", "then", "true", "until", "while"
    };
    localparam int KW_LEN [22] = '{
        3, 5, 2, 4, 6, 3, 5, 3, 8, 4, 2, 2, 5, 3, 3, 2, 6, 6, 4, 4, 5, 5
    };

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_chunk;
    } t_src;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [30:0] token_line;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic        run_last;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       rec0;
        t_tok       rec1;
    } t_push;

    typedef enum logic [24:0] {
        M_IDLE    = 25'h0000001,
        M_IDENT   = 25'h0000002,
        M_ZERO    = 25'h0000004,
        M_INT     = 25'h0000008,
        M_FRAC    = 25'h0000010,
        M_HINT    = 25'h0000020,
        M_HFRAC   = 25'h0000040,
        M_ESIGN   = 25'h0000080,
        M_ENEED   = 25'h0000100,
        M_EDIG    = 25'h0000200,
        M_OP      = 25'h0000400,
        M_DOT     = 25'h0000800,
        M_DOT2    = 25'h0001000,
        M_MINUS   = 25'h0002000,
        M_BRACK   = 25'h0004000,
        M_LOPEN   = 25'h0008000,
        M_LBODY   = 25'h0010000,
        M_LCLOSE  = 25'h0020000,
        M_SSTR    = 25'h0040000,
        M_SESC    = 25'h0080000,
        M_CDASH   = 25'h0100000,
        M_CBRACK  = 25'h0200000,
        M_LINECMT = 25'h0400000,
        M_CBODY   = 25'h0800000,
        M_CCLOSE  = 25'h1000000
    } t_mode;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_head(input logic [7:0] c);
        return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_nl(input logic [7:0] c);
        return c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            ";":     k = 6'd26;
            ",":     k = 6'd27;
            "(":     k = 6'd28;
            ")":     k = 6'd29;
            "]":     k = 6'd30;
            "{":     k = 6'd31;
            "}":     k = 6'd32;
            "+":     k = 6'd33;
            "*":     k = 6'd35;
            "^":     k = 6'd36;
            "%":     k = 6'd37;
            "&":     k = 6'd38;
            "|":     k = 6'd39;
            "#":     k = 6'd40;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] c);
        logic [5:0] k;
        k = K_EOF;
        if (a == ":" && c == ":") k = K_DCOLON;
        if (a == "/" && c == "/") k = K_IDIV;
        if (a == "~" && c == "=") k = K_NE;
        if (a == "=" && c == "=") k = K_EQ;
        if (a == "<" && c == "=") k = K_LE;
        if (a == "<" && c == "<") k = K_SHL;
        if (a == ">" && c == "=") k = K_GE;
        if (a == ">" && c == ">") k = K_SHR;
        return k;
    endfunction

    function automatic logic [5:0] lone_kind(input logic [7:0] a);
        logic [5:0] k;
        case (a)
            ":":     k = K_COLON;
            "/":     k = K_DIV;
            "~":     k = K_TILDE;
            "=":     k = K_ASSIGN;
            "<":     k = K_LT;
            ">":     k = K_GT;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    // kbytes holds buffer entry i at bits [8*i +: 8]
    function automatic logic [5:0] kw_kind(input logic [63:0] kbytes, input int unsigned len);
        logic [5:0] k_out;
        logic       hit;
        k_out = K_IDENT;
        for (int k = 0; k < 22; k++) begin
            hit = (len == KW_LEN[k]);
            for (int i = 0; i < 8; i++) begin
                if (i < KW_LEN[k]) begin
                    hit = hit && (kbytes[8*i +: 8] == KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]);
                end
            end
            if (hit) k_out = K_KW0 + 6'(k);
        end
        return k_out;
    endfunction

endpackage

>>> sv/lts_scan.sv
// Scanner state machine: one byte per beat, up to two token records per beat.
module lts_scan import lts_pkg::*; #(
    parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  t_src        i_src,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data,
    output t_push       o_push
);
    localparam int IL_W = $clog2(KEYWORD_BYTES + 2);
    localparam int KA_W = $clog2(KEYWORD_BYTES);
    localparam logic [LEVEL_BITS-1:0] LMAX = {LEVEL_BITS{1'b1}};

    t_mode                 r_mode, n_mode;
    logic [30:0]           r_first, r_line, n_line, r_tbl, n_tbl;
    logic [31:0]           r_off, n_off, r_tb, n_tb;
    logic [IL_W-1:0]       r_idlen, n_idlen;
    logic [LEVEL_BITS-1:0] r_open, n_open;
    logic [LEVEL_BITS:0]   r_close, n_close;
    logic [7:0]            r_held, n_held, r_quote, n_quote, r_lastnl, n_lastnl;
    logic                  r_err, n_err;
    logic [7:0]            r_kbuf [KEYWORD_BYTES];

    logic            kb_we;
    logic [KA_W-1:0] kb_wa;
    logic [63:0]     kbytes;
    logic            a_v, b_v, st;
    t_tok            rec_a, rec_b;
    logic [7:0]      b;
    logic [31:0]     p, nx;
    logic [5:0]      k1, kp;
    logic [30:0]     line_now, first_now;

    // a write to first_line lands before a byte taken in the same cycle while the chunk has seen no byte yet
    assign line_now  = (i_cfg_we && r_off == '0 && r_mode == M_IDLE) ? i_cfg_data : r_line;
    assign first_now = i_cfg_we ? i_cfg_data : r_first;

    always_comb begin
        for (int i = 0; i < 8; i++) kbytes[8*i +: 8] = r_kbuf[i];
    end

    always_comb begin
        n_mode = r_mode;   n_line = line_now; n_tbl = r_tbl;   n_off = r_off;
        n_tb = r_tb;       n_idlen = r_idlen; n_open = r_open; n_close = r_close;
        n_held = r_held;   n_quote = r_quote; n_lastnl = r_lastnl; n_err = r_err;
        kb_we = 1'b0;      kb_wa = '0;
        a_v = 1'b0;        b_v = 1'b0;        st = 1'b0;
        rec_a = '0;        rec_b = '0;
        b  = i_src.source_byte;
        p  = r_off;
        nx = (r_off == OFF_TOP) ? r_off : r_off + 32'd1;
        k1 = single_kind(b);
        kp = pair_kind(r_held, b);
        rec_a.token_line  = r_tbl;
        rec_a.token_start = r_tb;

        if (i_src.end_of_chunk) begin
            if (!r_err) begin
                rec_a.token_length = p - r_tb;
                a_v = 1'b1;
                case (r_mode)
                    M_IDENT: rec_a.token_kind = kw_kind(kbytes, 32'(r_idlen));
                    M_ZERO, M_INT, M_FRAC, M_HINT, M_HFRAC, M_EDIG:
                        rec_a.token_kind = K_NUMBER;
                    M_OP:    rec_a.token_kind = lone_kind(r_held);
                    M_DOT:   rec_a.token_kind = K_DOT;
                    M_DOT2:  rec_a.token_kind = K_CONCAT;
                    M_MINUS: rec_a.token_kind = K_MINUS;
                    M_BRACK: rec_a.token_kind = K_LBRACK;
                    M_IDLE, M_CDASH, M_CBRACK, M_LINECMT: a_v = 1'b0;
                    default: rec_a.token_kind = K_ERROR;
                endcase
            end
            b_v = 1'b1;
            rec_b = '{K_EOF, line_now, p, 32'd0, 1'b0};
            n_mode = M_IDLE;  n_line = first_now; n_off = '0;  n_tb = '0;
            n_tbl = '0;       n_idlen = '0;     n_open = '0;  n_close = '0;
            n_held = '0;      n_quote = '0;     n_lastnl = '0; n_err = 1'b0;
        end else begin
            if (!r_err) begin
                rec_a.token_length = p - r_tb;
                case (r_mode)
                    M_IDENT: begin
                        if (is_head(b) || is_digit(b)) begin
                            if (32'(r_idlen) < KEYWORD_BYTES) begin
                                kb_we = 1'b1;
                                kb_wa = r_idlen[KA_W-1:0];
                            end
                            if (32'(r_idlen) <= KEYWORD_BYTES) n_idlen = r_idlen + 1'b1;
                        end else begin
                            a_v = 1'b1; st = 1'b1;
                            rec_a.token_kind = kw_kind(kbytes, 32'(r_idlen));
                        end
                    end
                    M_ZERO, M_INT: begin
                        if (r_mode == M_ZERO && (b == "x" || b == "X")) n_mode = M_HINT;
                        else if (is_digit(b)) n_mode = M_INT;
                        else if (b == ".") n_mode = M_FRAC;
                        else if (b == "e" || b == "E") n_mode = M_ESIGN;
                        else begin
                            a_v = 1'b1; st = 1'b1; rec_a.token_kind = K_NUMBER;
                        end
                    end
                    M_FRAC: begin
                        if (is_digit(b)) n_mode = M_FRAC;
                        else if (b == "e" || b == "E") n_mode = M_ESIGN;
                        else begin
                            a_v = 1'b1; st = 1'b1; rec_a.token_kind = K_NUMBER;
                        end
                    end
                    M_HINT, M_HFRAC: begin
                        if (is_hex(b)) n_mode = r_mode;
                        else if (r_mode == M_HINT && b == ".") n_mode = M_HFRAC;
                        else if (b == "p" || b == "P") n_mode = M_ESIGN;
                        else begin
                            a_v = 1'b1; st = 1'b1; rec_a.token_kind = K_NUMBER;
                        end
                    end
                    M_ESIGN: begin
                        if (b == "+" || b == "-") n_mode = M_ENEED;
                        else if (is_digit(b)) n_mode = M_EDIG;
                        else begin
                            a_v = 1'b1; n_err = 1'b1; n_mode = M_IDLE;
                            rec_a.token_kind = K_ERROR;
                        end
                    end
                    M_ENEED: begin
                        if (is_digit(b)) n_mode = M_EDIG;
                        else begin
                            a_v = 1'b1; n_err = 1'b1; n_mode = M_IDLE;
                            rec_a.token_kind = K_ERROR;
                        end
                    end
                    M_EDIG: begin
                        if (!is_digit(b)) begin
                            a_v = 1'b1; st = 1'b1; rec_a.token_kind = K_NUMBER;
                        end
                    end
                    M_OP: begin
                        a_v = 1'b1;
                        if (kp != K_EOF) begin
                            rec_a.token_kind = kp; rec_a.token_length = nx - r_tb;
                            n_mode = M_IDLE;
                        end else begin
                            st = 1'b1; rec_a.token_kind = lone_kind(r_held);
                        end
                    end
                    M_DOT: begin
                        if (b == ".") n_mode = M_DOT2;
                        else if (is_digit(b)) n_mode = M_FRAC;
                        else begin
                            a_v = 1'b1; st = 1'b1; rec_a.token_kind = K_DOT;
                        end
                    end
                    M_DOT2: begin
                        a_v = 1'b1;
                        if (b == ".") begin
                            rec_a.token_kind = K_DOTS3; rec_a.token_length = nx - r_tb;
                            n_mode = M_IDLE;
                        end else begin
                            st = 1'b1; rec_a.token_kind = K_CONCAT;
                        end
                    end
                    M_MINUS: begin
                        if (b == "-") n_mode = M_CDASH;
                        else begin
                            a_v = 1'b1; st = 1'b1; rec_a.token_kind = K_MINUS;
                        end
                    end
                    M_BRACK: begin
                        if (b == "[") begin
                            n_open = '0; n_mode = M_LBODY;
                        end else if (b == "=") begin
                            n_open = LEVEL_BITS'(1); n_mode = M_LOPEN;
                        end else begin
                            a_v = 1'b1; st = 1'b1; rec_a.token_kind = K_LBRACK;
                        end
                    end
                    M_LOPEN, M_CBRACK: begin
                        if (b == "=") begin
                            if (r_open == LMAX) begin
                                a_v = 1'b1; n_err = 1'b1; n_mode = M_IDLE;
                                rec_a.token_kind = K_ERROR;
                            end else begin
                                n_open = r_open + 1'b1;
                            end
                        end else if (b == "[") begin
                            n_mode = (r_mode == M_LOPEN) ? M_LBODY : M_CBODY;
                        end else if (r_mode == M_LOPEN) begin
                            a_v = 1'b1; n_err = 1'b1; n_mode = M_IDLE;
                            rec_a.token_kind = K_ERROR;
                        end else begin
                            n_mode = is_nl(b) ? M_IDLE : M_LINECMT;
                        end
                    end
                    M_CDASH: begin
                        if (b == "[") begin
                            n_open = '0; n_mode = M_CBRACK;
                        end else begin
                            n_mode = is_nl(b) ? M_IDLE : M_LINECMT;
                        end
                    end
                    M_LINECMT: begin
                        if (is_nl(b)) n_mode = M_IDLE;
                    end
                    M_LBODY, M_CBODY: begin
                        if (b == "]") begin
                            n_close = '0;
                            n_mode = (r_mode == M_LBODY) ? M_LCLOSE : M_CCLOSE;
                        end
                    end
                    M_LCLOSE, M_CCLOSE: begin
                        if (b == "=") begin
                            if (r_close <= {1'b0, LMAX}) n_close = r_close + 1'b1;
                        end else if (b == "]") begin
                            if (r_close == {1'b0, r_open}) begin
                                n_mode = M_IDLE;
                                if (r_mode == M_LCLOSE) begin
                                    a_v = 1'b1; rec_a.token_kind = K_STRING;
                                    rec_a.token_length = nx - r_tb;
                                end
                            end else begin
                                n_close = '0;
                            end
                        end else begin
                            n_mode = (r_mode == M_LCLOSE) ? M_LBODY : M_CBODY;
                        end
                    end
                    M_SSTR: begin
                        if (b == "\\") n_mode = M_SESC;
                        else if (b == r_quote) begin
                            a_v = 1'b1; rec_a.token_kind = K_STRING;
                            rec_a.token_length = nx - r_tb; n_mode = M_IDLE;
                        end
                    end
                    M_SESC:  n_mode = M_SSTR;
                    default: st = 1'b1;
                endcase
            end

            if (st) begin
                n_mode = M_IDLE;
                n_tb   = p;
                n_tbl  = line_now;
                rec_b  = '{K_ERROR, line_now, p, nx - p, 1'b0};
                if (is_space(b)) begin
                    n_mode = M_IDLE;
                end else if (k1 != K_EOF) begin
                    b_v = 1'b1; rec_b.token_kind = k1; rec_b.token_length = 32'd1;
                end else if (b == ":" || b == "/" || b == "~" || b == "=" ||
                             b == "<" || b == ">") begin
                    n_held = b; n_mode = M_OP;
                end else if (b == ".") n_mode = M_DOT;
                else if (b == "-") n_mode = M_MINUS;
                else if (b == "[") n_mode = M_BRACK;
                else if (b == "'" || b == "\"") begin
                    n_quote = b; n_mode = M_SSTR;
                end else if (b == "0") n_mode = M_ZERO;
                else if (is_digit(b)) n_mode = M_INT;
                else if (is_head(b)) begin
                    kb_we = 1'b1; kb_wa = '0;
                    n_idlen = IL_W'(1); n_mode = M_IDENT;
                end else begin
                    b_v = 1'b1; n_err = 1'b1;
                end
            end

            // CR/LF or LF/CR counts as one line break
            if (is_nl(b)) begin
                if (r_lastnl != 8'd0 && r_lastnl != b) begin
                    n_lastnl = 8'd0;
                end else begin
                    if (line_now < LINE_TOP) n_line = line_now + 31'd1;
                    n_lastnl = b;
                end
            end else begin
                n_lastnl = 8'd0;
            end
            n_off = nx;
        end
    end

    always_comb begin
        o_push = '0;
        if (i_go) begin
            o_push.cnt  = 2'(a_v) + 2'(b_v);
            o_push.rec0 = a_v ? rec_a : rec_b;
            o_push.rec1 = rec_b;
            if (a_v && b_v) o_push.rec1.run_last = 1'b1;
            else            o_push.rec0.run_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;  r_first <= 31'd1; r_line <= 31'd1; r_off <= '0;
            r_tb <= '0;        r_tbl <= '0;      r_idlen <= '0;   r_open <= '0;
            r_close <= '0;     r_held <= '0;     r_quote <= '0;   r_lastnl <= '0;
            r_err <= 1'b0;
        end else begin
            if (i_cfg_we) r_first <= i_cfg_data;
            if (i_go) begin
                r_mode <= n_mode;  r_line <= n_line;  r_off <= n_off;   r_tb <= n_tb;
                r_tbl <= n_tbl;    r_idlen <= n_idlen; r_open <= n_open;
                r_close <= n_close; r_held <= n_held; r_quote <= n_quote;
                r_lastnl <= n_lastnl; r_err <= n_err;
            end else begin
                r_line <= line_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && kb_we) r_kbuf[kb_wa] <= b;
    end

endmodule

>>> sv/lts_fifo.sv
// Output record queue: takes up to two records per beat, delivers one per beat.
module lts_fifo import lts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_stall,
    output t_tok  o_data
);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_tok          r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    // room for the two records a single beat may produce
    assign o_full  = r_cnt > CW'(FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push.cnt);
            r_rp  <= r_rp + PW'(pop);
            r_cnt <= r_cnt + CW'(i_push.cnt) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wp] <= i_push.rec0;
        if (i_push.cnt == 2'd2) r_mem[r_wp + PW'(1)] <= i_push.rec1;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(FIFO_DEPTH)) else $error("record queue overflow");
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt == 2'd2 |-> i_push.rec1.run_last && !i_push.rec0.run_last)
        else $error("run_last misplaced in record pair");
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_push.cnt == 2'd0 |=> r_cnt == $past(r_cnt) - CW'(1))
        else $error("record count did not drop on pop");
endmodule

>>> sv/lua_token_scanner_core.sv
// Top level of the source token scanner.
// Input channel: one beat per source byte (or an end-of-chunk marker),
// accepted when i_in_valid is high and o_in_stall is low.
// Output channel: one token record per beat, taken when o_out_valid is
// high and i_out_stall is low; run_last marks the final record of a byte.
// Config channel: i_cfg_valid/o_cfg_ready write first_line; ready is
// always high. The value applies at the next chunk, or at once when the
// current chunk has seen no byte yet.
// A record caused by a byte is written to the record queue when the byte
// is accepted. Throughput: one byte per cycle while o_in_stall is low,
// set by the single state update per byte; a byte may yield two records,
// drained one per cycle while i_out_stall is low via a four-entry queue.
// o_in_stall rises when the queue has fewer than two free entries, so a
// stalled receiver backs up to the source after at most four records.
// Reset (synchronous, active low) empties the queue, returns the scanner
// to idle between tokens at line 1, offset 0, and sets first_line to 1.
module lua_token_scanner_core import lts_pkg::*; #(
    parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_src        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_tok        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);
    t_push push;
    logic  full;
    logic  go;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign go          = i_in_valid && !full;

    lts_scan #(
        .KEYWORD_BYTES(KEYWORD_BYTES),
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_src     (i_in_data),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_data(i_cfg_data),
        .o_push    (push)
    );

    lts_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_data (o_out_data)
    );
endmodule
